@@ rtl/bpdc_pkg.sv @@
// shared types and constants for the two-beam direction counter
package bpdc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OCC_W       = 16;
    localparam int TICK_W      = 8;
    localparam int MS_W        = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_EDGE = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ENTRY  = 2'd1,
        EV_EXIT   = 2'd2,
        EV_REJECT = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_MS    = 2'd0,
        CFG_MIN_CROSSING_MS = 2'd1,
        CFG_MAX_CROSSING_MS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic req_type;
        logic beam_one_level;
        logic beam_two_level;
    } t_req;

    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        t_event           crossing_event;
    } t_rsp;

    typedef struct packed {
        logic [TICK_W-1:0] ticks_per_ms;
        logic [MS_W-1:0]   min_crossing_ms;
        logic [MS_W-1:0]   max_crossing_ms;
    } t_cfg;

endpackage

@@ rtl/bpdc_cfg.sv @@
// configuration registers for the two-beam direction counter
module bpdc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bpdc_pkg::t_cfg                      o_cfg
);

    bpdc_pkg::t_cfg r_cfg;
    bpdc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpdc_pkg::CFG_TICKS_PER_MS:
                    n_cfg.ticks_per_ms = i_cfg_data[bpdc_pkg::TICK_W-1:0];
                bpdc_pkg::CFG_MIN_CROSSING_MS:
                    n_cfg.min_crossing_ms = i_cfg_data[bpdc_pkg::MS_W-1:0];
                bpdc_pkg::CFG_MAX_CROSSING_MS:
                    n_cfg.max_crossing_ms = i_cfg_data[bpdc_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_ms    <= bpdc_pkg::TICK_W'(4);
            r_cfg.min_crossing_ms <= bpdc_pkg::MS_W'(50);
            r_cfg.max_crossing_ms <= bpdc_pkg::MS_W'(2000);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bpdc_engine.sv @@
// timer, beam pairing and occupancy state with the per-word update logic
module bpdc_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  bpdc_pkg::t_req  i_req,
    input  bpdc_pkg::t_cfg  i_cfg,
    output bpdc_pkg::t_rsp  o_rsp
);

    localparam logic [bpdc_pkg::COUNT_WIDTH-1:0] CountMax = '1;
    localparam logic [bpdc_pkg::MS_W-1:0]        MsMax    = '1;

    logic [bpdc_pkg::TICK_W-1:0]      r_prescale, n_prescale;
    logic [bpdc_pkg::MS_W-1:0]        r_elapsed, n_elapsed;
    logic                             r_first, n_first;
    logic                             r_second, n_second;
    logic [bpdc_pkg::COUNT_WIDTH-1:0] r_people, n_people;
    logic [bpdc_pkg::TICK_W-1:0]      dec;
    logic                             win_ok;
    bpdc_pkg::t_event                 ev;

    assign dec    = r_prescale - bpdc_pkg::TICK_W'(1);
    assign win_ok = (r_elapsed >= i_cfg.min_crossing_ms) &&
                    (r_elapsed <= i_cfg.max_crossing_ms);

    always_comb begin
        n_prescale = r_prescale;
        n_elapsed  = r_elapsed;
        n_first    = r_first;
        n_second   = r_second;
        n_people   = r_people;
        ev         = bpdc_pkg::EV_NONE;
        if (i_req.req_type == bpdc_pkg::REQ_TICK) begin
            n_prescale = dec;
            if (dec == '0) begin
                n_prescale = i_cfg.ticks_per_ms;
                if (r_elapsed != MsMax) begin
                    n_elapsed = r_elapsed + bpdc_pkg::MS_W'(1);
                end
            end
        end else if (i_req.beam_two_level) begin
            n_second   = 1'b1;
            n_prescale = i_cfg.ticks_per_ms;
            n_elapsed  = '0;
            if (r_first) begin
                if (win_ok) begin
                    ev = bpdc_pkg::EV_ENTRY;
                    if (r_people != CountMax) begin
                        n_people = r_people + bpdc_pkg::COUNT_WIDTH'(1);
                    end
                end else begin
                    ev = bpdc_pkg::EV_REJECT;
                end
                n_first  = 1'b0;
                n_second = 1'b0;
            end
        end else if (i_req.beam_one_level) begin
            n_first    = 1'b1;
            n_prescale = i_cfg.ticks_per_ms;
            n_elapsed  = '0;
            if (r_second) begin
                if (win_ok) begin
                    ev = bpdc_pkg::EV_EXIT;
                    if (r_people != '0) begin
                        n_people = r_people - bpdc_pkg::COUNT_WIDTH'(1);
                    end
                end else begin
                    ev = bpdc_pkg::EV_REJECT;
                end
                n_first  = 1'b0;
                n_second = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_elapsed  <= '0;
            r_first    <= 1'b0;
            r_second   <= 1'b0;
            r_people   <= bpdc_pkg::COUNT_WIDTH'(1);
        end else if (i_fire) begin
            r_prescale <= n_prescale;
            r_elapsed  <= n_elapsed;
            r_first    <= n_first;
            r_second   <= n_second;
            r_people   <= n_people;
        end
    end

    // occupancy reported after this word
    assign o_rsp.occupancy      = bpdc_pkg::OCC_W'(n_people);
    assign o_rsp.crossing_event = ev;

    // a pair always clears both flags, so they never stand together
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_first && r_second))
        else $error("both beam flags set");

    // any edge with a beam high restarts the millisecond timer
    a_timer_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == bpdc_pkg::REQ_EDGE &&
         (i_req.beam_one_level || i_req.beam_two_level)) |=> (r_elapsed == '0))
        else $error("timer not restarted on beam edge");

    // ticks never move the occupancy count
    a_tick_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == bpdc_pkg::REQ_TICK) |=> $stable(r_people))
        else $error("tick changed occupancy");

    // a counted entry below the limit raises occupancy by one
    a_entry_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && ev == bpdc_pkg::EV_ENTRY && r_people != CountMax)
        |=> (r_people == $past(r_people) + bpdc_pkg::COUNT_WIDTH'(1)))
        else $error("entry not counted");

endmodule

@@ rtl/beam_pair_direction_counter_core.sv @@
// top level of the two-beam direction counter: input register, update logic, result register
// a word accepted into the input register passes through the update logic into the result register, shown on o_valid
// throughput: one word per cycle, limited only by stall on the result side
// while a finished result waits to be taken the input register takes one more word, then stalls
// reset (synchronous, active low) empties both registers, sets occupancy to 1,
// clears timer and beam flags and loads the default timing window
module beam_pair_direction_counter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  bpdc_pkg::t_req                      i_req,
    output logic                                o_valid,
    input  logic                                i_stall,
    output bpdc_pkg::t_rsp                      o_rsp,
    input  logic                                i_cfg_we,
    input  logic [bpdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic           r_in_valid;
    bpdc_pkg::t_req r_in;
    logic           r_out_valid;
    bpdc_pkg::t_rsp r_out;
    logic           in_fire;
    logic           advance;
    bpdc_pkg::t_cfg cfg;
    bpdc_pkg::t_rsp rsp;

    // word moves into the result register when that slot is free or draining
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_fire = i_valid && !o_stall;

    bpdc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bpdc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_req;
        end
        if (advance) begin
            r_out <= rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule
